/* hw/rtl/euler_polynomial_ode_step_top_assert.svh */
// Assertion macros used by the checker file of the Euler integrator.
`ifndef EULER_POLYNOMIAL_ODE_STEP_TOP_ASSERT_SVH
`define EULER_POLYNOMIAL_ODE_STEP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define EPS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eps checker: same-cycle property failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define EPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eps checker: next-cycle property failed");

`endif

/* hw/rtl/eps_pkg.sv */
// Types, constants and fixed-point helpers of the Euler integrator.
package eps_pkg;

  localparam int MAX_DEGREE = 7;
  localparam int COEF_DEPTH = MAX_DEGREE + 1;
  localparam int IDX_W      = $clog2(COEF_DEPTH);
  localparam int Q_W        = 32;
  localparam int FRAC_W     = 16;
  localparam int DEG_W      = 3;
  localparam int FIDX_W     = 3;
  localparam int ITER_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int PC_W       = 4;

  localparam logic signed [Q_W-1:0] STEP_SIZE_RESET = 32'sd65536;
  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_LOAD_X,
    REQ_LOAD_Y,
    REQ_START,
    REQ_STEP
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE,
    CFG_DEGREE_X,
    CFG_DEGREE_Y
  } cfg_reg_t;

  typedef struct packed {
    req_t                    req_type;
    logic [FIDX_W-1:0]       coef_index;
    logic signed [Q_W-1:0]   coef_value;
    logic signed [Q_W-1:0]   start_x;
    logic signed [Q_W-1:0]   start_y;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0]   new_y;
    logic [ITER_W-1:0]       iteration;
    logic                    overflow;
  } out_item_t;

  typedef logic [PC_W-1:0] pc_t;

  // Microprogram step addresses.
  localparam pc_t PC_IDLE   = 4'd0;
  localparam pc_t PC_LOAD_P = 4'd1;
  localparam pc_t PC_MUL_X  = 4'd2;
  localparam pc_t PC_MAC_X  = 4'd3;
  localparam pc_t PC_LOAD_Q = 4'd4;
  localparam pc_t PC_MUL_Y  = 4'd5;
  localparam pc_t PC_MAC_Y  = 4'd6;
  localparam pc_t PC_SUM_F  = 4'd7;
  localparam pc_t PC_MUL_H  = 4'd8;
  localparam pc_t PC_UPD_Y  = 4'd9;
  localparam pc_t PC_WAIT   = 4'd10;
  localparam pc_t PC_EMIT   = 4'd11;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_COEF_TOP,
    ACC_MAC,
    ACC_SUM,
    ACC_UPDATE
  } acc_op_t;

  typedef enum logic [1:0] {
    MUL_X,
    MUL_Y,
    MUL_H
  } mul_src_t;

  typedef enum logic {
    TAB_X,
    TAB_Y
  } tab_t;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_NO_START,
    JMP_DEG_ZERO,
    JMP_CNT_MORE,
    JMP_OUT_BUSY
  } jmp_t;

  typedef struct packed {
    acc_op_t  acc_op;
    logic     mul_en;
    mul_src_t mul_src;
    tab_t     tab;
    logic     clr_ovf;
    logic     save_p;
    logic     commit;
    jmp_t     jmp;
    pc_t      target;
  } ctrl_t;

  typedef struct packed {
    logic deg_zero;
    logic cnt_more;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic                  ovf;
    logic signed [Q_W-1:0] val;
  } sat_t;

  // Exact sum of two Q16.16 values, saturated to the word.
  function automatic sat_t sat_sum(logic signed [Q_W-1:0] a, logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    sat_t                r;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) begin
      r.ovf = 1'b1;
      r.val = s[Q_W] ? Q_MIN : Q_MAX;
    end else begin
      r.ovf = 1'b0;
      r.val = s[Q_W-1:0];
    end
    return r;
  endfunction

  // Full product shifted down by the fraction width (floor), then saturated.
  function automatic sat_t sat_prod(logic signed [2*Q_W-1:0] p);
    logic signed [2*Q_W-1:0] sh;
    sat_t                    r;
    sh = p >>> FRAC_W;
    if ((&sh[2*Q_W-1:Q_W-1]) || !(|sh[2*Q_W-1:Q_W-1])) begin
      r.ovf = 1'b0;
      r.val = sh[Q_W-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = sh[2*Q_W-1] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

  // Degrees above the table size use the highest entry.
  function automatic logic [IDX_W-1:0] clamp_deg(logic [DEG_W-1:0] d);
    logic [IDX_W-1:0] r;
    if (32'(d) > 32'(MAX_DEGREE)) begin
      r = IDX_W'(MAX_DEGREE);
    end else begin
      r = IDX_W'(d);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/eps_ucode_rom.sv */
// Microcode ROM: one control word for each step of the Euler step program.
module eps_ucode_rom (
  input  eps_pkg::pc_t   pc,
  output eps_pkg::ctrl_t cw
);

  always_comb begin
    cw.acc_op  = eps_pkg::ACC_HOLD;
    cw.mul_en  = 1'b0;
    cw.mul_src = eps_pkg::MUL_X;
    cw.tab     = eps_pkg::TAB_X;
    cw.clr_ovf = 1'b0;
    cw.save_p  = 1'b0;
    cw.commit  = 1'b0;
    cw.jmp     = eps_pkg::JMP_NONE;
    cw.target  = eps_pkg::PC_IDLE;
    case (pc)
      eps_pkg::PC_IDLE: begin
        cw.jmp    = eps_pkg::JMP_NO_START;
        cw.target = eps_pkg::PC_IDLE;
      end
      eps_pkg::PC_LOAD_P: begin
        cw.acc_op  = eps_pkg::ACC_COEF_TOP;
        cw.tab     = eps_pkg::TAB_X;
        cw.clr_ovf = 1'b1;
        cw.jmp     = eps_pkg::JMP_DEG_ZERO;
        cw.target  = eps_pkg::PC_LOAD_Q;
      end
      eps_pkg::PC_MUL_X: begin
        cw.mul_en  = 1'b1;
        cw.mul_src = eps_pkg::MUL_X;
      end
      eps_pkg::PC_MAC_X: begin
        cw.acc_op = eps_pkg::ACC_MAC;
        cw.tab    = eps_pkg::TAB_X;
        cw.jmp    = eps_pkg::JMP_CNT_MORE;
        cw.target = eps_pkg::PC_MUL_X;
      end
      eps_pkg::PC_LOAD_Q: begin
        cw.acc_op = eps_pkg::ACC_COEF_TOP;
        cw.tab    = eps_pkg::TAB_Y;
        cw.save_p = 1'b1;
        cw.jmp    = eps_pkg::JMP_DEG_ZERO;
        cw.target = eps_pkg::PC_SUM_F;
      end
      eps_pkg::PC_MUL_Y: begin
        cw.mul_en  = 1'b1;
        cw.mul_src = eps_pkg::MUL_Y;
      end
      eps_pkg::PC_MAC_Y: begin
        cw.acc_op = eps_pkg::ACC_MAC;
        cw.tab    = eps_pkg::TAB_Y;
        cw.jmp    = eps_pkg::JMP_CNT_MORE;
        cw.target = eps_pkg::PC_MUL_Y;
      end
      eps_pkg::PC_SUM_F: begin
        cw.acc_op = eps_pkg::ACC_SUM;
      end
      eps_pkg::PC_MUL_H: begin
        cw.mul_en  = 1'b1;
        cw.mul_src = eps_pkg::MUL_H;
      end
      eps_pkg::PC_UPD_Y: begin
        cw.acc_op = eps_pkg::ACC_UPDATE;
      end
      eps_pkg::PC_WAIT: begin
        cw.jmp    = eps_pkg::JMP_OUT_BUSY;
        cw.target = eps_pkg::PC_WAIT;
      end
      eps_pkg::PC_EMIT: begin
        cw.commit = 1'b1;
        cw.jmp    = eps_pkg::JMP_ALWAYS;
        cw.target = eps_pkg::PC_IDLE;
      end
      default: begin
        cw.jmp    = eps_pkg::JMP_ALWAYS;
        cw.target = eps_pkg::PC_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/eps_seq.sv */
// Microprogram sequencer: step counter, ROM lookup and conditional jumps.
module eps_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  eps_pkg::dp_stat_t stat,
  output eps_pkg::ctrl_t    cw,
  output logic              busy
);

  eps_pkg::pc_t pc_r;
  eps_pkg::pc_t pc_nxt;
  logic         take;

  eps_ucode_rom u_rom (
    .pc (pc_r),
    .cw (cw)
  );

  always_comb begin
    case (cw.jmp)
      eps_pkg::JMP_NONE:     take = 1'b0;
      eps_pkg::JMP_ALWAYS:   take = 1'b1;
      eps_pkg::JMP_NO_START: take = !start;
      eps_pkg::JMP_DEG_ZERO: take = stat.deg_zero;
      eps_pkg::JMP_CNT_MORE: take = stat.cnt_more;
      eps_pkg::JMP_OUT_BUSY: take = stat.out_busy;
      default:               take = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt = take ? cw.target : pc_r + eps_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= eps_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign busy = (pc_r != eps_pkg::PC_IDLE);

endmodule

/* hw/rtl/eps_datapath.sv */
// Datapath: coefficient tables, state, shared multiplier and saturating adder, result register.
module eps_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  eps_pkg::ctrl_t                        cw,
  input  logic                                  load_fire,
  input  eps_pkg::in_item_t                     in_item,
  input  logic                                  cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [eps_pkg::Q_W-1:0]               cfg_wdata,
  input  logic                                  out_stall,
  output eps_pkg::dp_stat_t                     stat,
  output logic                                  out_valid,
  output eps_pkg::out_item_t                    out_item
);

  logic signed [eps_pkg::Q_W-1:0]   h_r;
  logic [eps_pkg::DEG_W-1:0]        dx_r;
  logic [eps_pkg::DEG_W-1:0]        dy_r;
  logic signed [eps_pkg::Q_W-1:0]   xcoef_r [eps_pkg::COEF_DEPTH];
  logic signed [eps_pkg::Q_W-1:0]   ycoef_r [eps_pkg::COEF_DEPTH];
  logic signed [eps_pkg::Q_W-1:0]   cur_x_r;
  logic signed [eps_pkg::Q_W-1:0]   cur_y_r;
  logic [eps_pkg::ITER_W-1:0]       step_cnt_r;
  logic signed [eps_pkg::Q_W-1:0]   acc_r;
  logic signed [eps_pkg::Q_W-1:0]   acc_nxt;
  logic signed [2*eps_pkg::Q_W-1:0] prod_r;
  logic signed [2*eps_pkg::Q_W-1:0] prod_nxt;
  logic signed [eps_pkg::Q_W-1:0]   p_r;
  logic [eps_pkg::IDX_W-1:0]        cnt_r;
  logic [eps_pkg::IDX_W-1:0]        cnt_nxt;
  logic                             ovf_r;
  logic                             ovf_nxt;
  logic                             out_valid_r;
  eps_pkg::out_item_t               out_item_r;

  logic [eps_pkg::IDX_W-1:0]        deg_x_eff;
  logic [eps_pkg::IDX_W-1:0]        deg_y_eff;
  logic [eps_pkg::IDX_W-1:0]        deg_eff;
  logic [eps_pkg::IDX_W-1:0]        cnt_m1;
  logic signed [eps_pkg::Q_W-1:0]   coef_top;
  logic signed [eps_pkg::Q_W-1:0]   coef_next;
  logic signed [eps_pkg::Q_W-1:0]   mul_b;
  logic signed [eps_pkg::Q_W-1:0]   add_a;
  logic signed [eps_pkg::Q_W-1:0]   add_b;
  logic                             add_ovf;
  logic                             idx_ok;
  eps_pkg::sat_t                    mulq;
  eps_pkg::sat_t                    sum;
  eps_pkg::sat_t                    xadv;

  assign deg_x_eff = eps_pkg::clamp_deg(dx_r);
  assign deg_y_eff = eps_pkg::clamp_deg(dy_r);
  assign deg_eff   = (cw.tab == eps_pkg::TAB_X) ? deg_x_eff : deg_y_eff;
  assign cnt_m1    = cnt_r - eps_pkg::IDX_W'(1);
  assign coef_top  = (cw.tab == eps_pkg::TAB_X) ? xcoef_r[deg_x_eff] : ycoef_r[deg_y_eff];
  assign coef_next = (cw.tab == eps_pkg::TAB_X) ? xcoef_r[cnt_m1] : ycoef_r[cnt_m1];
  assign idx_ok    = (32'(in_item.coef_index) <= 32'(eps_pkg::MAX_DEGREE));

  // Multiplier operand B; operand A is always the accumulator.
  always_comb begin
    case (cw.mul_src)
      eps_pkg::MUL_X: mul_b = cur_x_r;
      eps_pkg::MUL_Y: mul_b = cur_y_r;
      eps_pkg::MUL_H: mul_b = h_r;
      default:        mul_b = h_r;
    endcase
  end

  assign prod_nxt = acc_r * mul_b;
  assign mulq     = eps_pkg::sat_prod(prod_r);

  // One saturating adder serves the Horner step, the sum of P and Q and the y update.
  always_comb begin
    add_a = (cw.acc_op == eps_pkg::ACC_SUM) ? p_r : mulq.val;
    case (cw.acc_op)
      eps_pkg::ACC_MAC: add_b = coef_next;
      eps_pkg::ACC_SUM: add_b = acc_r;
      default:          add_b = cur_y_r;
    endcase
  end

  assign sum     = eps_pkg::sat_sum(add_a, add_b);
  assign add_ovf = sum.ovf | ((cw.acc_op != eps_pkg::ACC_SUM) & mulq.ovf);
  assign xadv    = eps_pkg::sat_sum(cur_x_r, h_r);

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    ovf_nxt = cw.clr_ovf ? 1'b0 : ovf_r;
    case (cw.acc_op)
      eps_pkg::ACC_HOLD: begin
        acc_nxt = acc_r;
      end
      eps_pkg::ACC_COEF_TOP: begin
        acc_nxt = coef_top;
        cnt_nxt = deg_eff;
      end
      eps_pkg::ACC_MAC: begin
        acc_nxt = sum.val;
        cnt_nxt = cnt_m1;
        ovf_nxt = ovf_r | add_ovf;
      end
      eps_pkg::ACC_SUM,
      eps_pkg::ACC_UPDATE: begin
        acc_nxt = sum.val;
        ovf_nxt = ovf_r | add_ovf;
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  assign stat.deg_zero = (deg_eff == '0);
  assign stat.cnt_more = (cnt_r != eps_pkg::IDX_W'(1));
  assign stat.out_busy = out_valid_r & out_stall;

  // Working registers of the step; they carry no reset.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (cw.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cw.save_p) begin
      p_r <= acc_r;
    end
    if (cw.commit) begin
      out_item_r.new_y     <= acc_r;
      out_item_r.iteration <= step_cnt_r;
      out_item_r.overflow  <= ovf_r | xadv.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else begin
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r  <= eps_pkg::STEP_SIZE_RESET;
      dx_r <= '0;
      dy_r <= '0;
    end else if (cfg_we) begin
      case (eps_pkg::cfg_reg_t'(cfg_index))
        eps_pkg::CFG_STEP_SIZE: h_r  <= cfg_wdata;
        eps_pkg::CFG_DEGREE_X:  dx_r <= cfg_wdata[eps_pkg::DEG_W-1:0];
        eps_pkg::CFG_DEGREE_Y:  dy_r <= cfg_wdata[eps_pkg::DEG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < eps_pkg::COEF_DEPTH; i++) begin
        xcoef_r[i] <= '0;
        ycoef_r[i] <= '0;
      end
    end else if (load_fire && idx_ok) begin
      if (in_item.req_type == eps_pkg::REQ_LOAD_X) begin
        xcoef_r[eps_pkg::IDX_W'(in_item.coef_index)] <= in_item.coef_value;
      end else if (in_item.req_type == eps_pkg::REQ_LOAD_Y) begin
        ycoef_r[eps_pkg::IDX_W'(in_item.coef_index)] <= in_item.coef_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      step_cnt_r <= '0;
    end else if (load_fire && (in_item.req_type == eps_pkg::REQ_START)) begin
      cur_x_r    <= in_item.start_x;
      cur_y_r    <= in_item.start_y;
      step_cnt_r <= '0;
    end else if (cw.commit) begin
      cur_x_r    <= xadv.val;
      cur_y_r    <= acc_r;
      step_cnt_r <= step_cnt_r + eps_pkg::ITER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cw.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* hw/rtl/euler_polynomial_ode_step_top.sv */
// Top level of the explicit Euler integrator for dy/dx = P(x) + Q(y) in Q16.16.
//
// Each transfer on the input channel either loads one coefficient of P or Q, sets the
// start point (x, y) and clears the iteration number, or takes one Euler step. Loads and
// set-start items give no result and leave the input channel open for the next item. A
// step item evaluates P at the current x and Q at the current y by Horner's rule, forms
// y + h*(P + Q), stores the new y, advances x by h and delivers one result holding the new
// y, the iteration number (zero for the first step after a start) and a flag that is set
// when any multiply or add of that step, the x advance included, saturated. A step keeps
// the input channel closed until its result is written to the output register; the result
// becomes visible in the same cycle in which the block takes input again. The block has a
// single 32x32 multiplier and a shared saturating adder, which a microcoded sequencer
// drives through one multiply step and one add step per Horner term, followed by the sum
// of both polynomials, the multiply by h and the y update. A finished result waits in an
// output register, so the block takes new items while the result is stalled; a following
// step holds at its final write only if that register is still occupied. Both coefficient
// tables reset to zero, step_size to 1.0 and both degrees to zero; there is no clearing
// pass after reset. Configuration writes are expected only while the block is idle; a
// write to an index past the last register is ignored.
module euler_polynomial_ode_step_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  eps_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output eps_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eps_pkg::Q_W-1:0]       cfg_wdata
);

  eps_pkg::ctrl_t    cw;
  eps_pkg::dp_stat_t stat;
  logic              busy;
  logic              in_fire;
  logic              start;
  logic              load_fire;

  // The input channel is open only while the sequencer sits in its idle step.
  assign in_stall  = busy;
  assign in_fire   = in_valid & !busy;
  assign start     = in_fire & (in_item.req_type == eps_pkg::REQ_STEP);
  assign load_fire = in_fire & (in_item.req_type != eps_pkg::REQ_STEP);

  eps_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cw    (cw),
    .busy  (busy)
  );

  eps_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cw        (cw),
    .load_fire (load_fire),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* hw/rtl/eps_checker.sv */
// Port-level checker of the Euler integrator and its bind to the top level.
`include "euler_polynomial_ode_step_top_assert.svh"

module eps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input eps_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input eps_pkg::out_item_t out_item
);

  // A held result keeps its value until it is taken.
  `EPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

  // A step transfer closes the input channel in the next cycle.
  `EPS_ASSERT_NEXT(a_step_busy, in_valid && !in_stall && in_item.req_type == eps_pkg::REQ_STEP,
                   in_stall)

  // Loads and set-start items leave the input channel open in the next cycle.
  `EPS_ASSERT_NEXT(a_load_fast, in_valid && !in_stall && in_item.req_type != eps_pkg::REQ_STEP,
                   !in_stall)

  // A new result only appears at the end of a step's busy period.
  `EPS_ASSERT_NOW(a_result_after_step, $rose(out_valid), $past(in_stall))

endmodule

bind euler_polynomial_ode_step_top eps_checker u_eps_checker (.*);
